>>> rtl/core/asp_pkg.sv
// Package for the address stride profiler.
// Holds table geometry, command codes, the entry layout and shared helpers.
// No dependencies.
package asp_pkg;

   localparam int THREADS = 16;
   localparam int SLOTS = 4;
   localparam int ENTRIES = THREADS * SLOTS;
   localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ROW_W = (THREADS > 1) ? $clog2(THREADS) : 1;

   localparam int ADDR_W = 48;
   localparam int STRIDE_W = 31;
   localparam int COUNT_W = 48;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_SAMPLE = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [ADDR_W-1:0] STRIDE_LIMIT = ADDR_W'({STRIDE_W{1'b1}});

   typedef struct packed {
      logic [ADDR_W-1:0]   last_seen;
      logic [ADDR_W-1:0]   low_mark;
      logic [ADDR_W-1:0]   high_mark;
      logic [COUNT_W-1:0]  sample_total;
      logic [STRIDE_W-1:0] stride_a;
      logic [COUNT_W-1:0]  tally_a;
      logic [STRIDE_W-1:0] stride_b;
      logic [COUNT_W-1:0]  tally_b;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   localparam entry_type ENTRY_RESET = '{
      last_seen: '0,
      low_mark: '1,
      high_mark: '0,
      sample_total: '0,
      stride_a: '0,
      tally_a: '0,
      stride_b: '0,
      tally_b: '0
   };

   typedef struct packed {
      logic load;
      logic step1;
      logic step2;
   } ctrl_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = (value == COUNT_MAX) ? value : value + COUNT_W'(1);
      return result;
   endfunction

endpackage

>>> rtl/core/asp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameterized by data width and depth; no dependencies.
module asp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/asp_valid.sv
// Valid bits for the profiler table, one per entry.
// A clear command drops a whole thread row at once. Depends on asp_pkg.
module asp_valid
   import asp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               set_en,
   input  logic [ENTRY_W-1:0] set_index,
   input  logic               clear_en,
   input  logic [ROW_W-1:0]   clear_row,
   input  logic [ENTRY_W-1:0] rd_index,
   output logic               rd_valid
);

   logic [ENTRIES-1:0] valid_ff;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_valid
      localparam int ROW = i / SLOTS;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (clear_en && (clear_row == ROW_W'(ROW))) begin
            valid_ff[i] <= 1'b0;
         end else if (set_en && (set_index == ENTRY_W'(i))) begin
            valid_ff[i] <= 1'b1;
         end
      end
   end

   assign rd_valid = valid_ff[rd_index];

endmodule

>>> rtl/core/asp_update.sv
// Entry update datapath: loads an entry, then applies a sample in two stages.
// Stage one updates bounds, count and stride; stage two runs the majority counter.
// Depends on asp_pkg.
module asp_update
   import asp_pkg::*;
(
   input  logic              clock,
   input  ctrl_type          ctrl,
   input  entry_type         rd_entry,
   input  logic              rd_valid,
   input  logic              is_sample,
   input  logic              is_clear,
   input  logic [ADDR_W-1:0] address,
   output entry_type         entry
);

   entry_type           work_ff;
   entry_type           work_in;
   logic [STRIDE_W-1:0] diff_ff;
   logic [STRIDE_W-1:0] diff_in;
   logic [ADDR_W-1:0]   distance;

   always_comb begin
      work_in = work_ff;
      diff_in = diff_ff;
      distance = (address >= work_ff.last_seen) ? address - work_ff.last_seen
                                                : work_ff.last_seen - address;
      if (ctrl.load) begin
         work_in = (is_clear || !rd_valid) ? ENTRY_RESET : rd_entry;
      end else if (ctrl.step1 && is_sample) begin
         if (address < work_ff.low_mark) begin
            work_in.low_mark = address;
         end
         if (address > work_ff.high_mark) begin
            work_in.high_mark = address;
         end
         work_in.sample_total = sat_inc(work_ff.sample_total);
         work_in.last_seen = address;
         diff_in = (distance > STRIDE_LIMIT) ? STRIDE_LIMIT[STRIDE_W-1:0]
                                             : distance[STRIDE_W-1:0];
      end else if (ctrl.step2 && is_sample) begin
         if (work_ff.stride_a == diff_ff) begin
            work_in.tally_a = sat_inc(work_ff.tally_a);
         end else if (work_ff.stride_b == diff_ff) begin
            work_in.tally_b = sat_inc(work_ff.tally_b);
         end else if (work_ff.tally_a == '0) begin
            work_in.stride_a = diff_ff;
         end else if (work_ff.tally_b == '0) begin
            work_in.stride_b = diff_ff;
         end else if (work_ff.tally_b >= work_ff.tally_a) begin
            work_in.tally_b = work_ff.tally_b - COUNT_W'(1);
         end else begin
            work_in.tally_a = work_ff.tally_a - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      diff_ff <= diff_in;
   end

   assign entry = work_ff;

endmodule

>>> rtl/core/address_stride_profiler.sv
// Top level of the address stride profiler.
// Depends on asp_pkg, asp_ram, asp_valid and asp_update.
//
// A request is taken at a rising edge with start high and busy low. It carries
// a command (clear thread, sample address, read slot), a thread, a slot and an
// address. The thread and slot select one entry of a table held in one RAM.
// Every request returns one response: the statistics of the addressed entry
// after the command's effect, shown on the rsp_ ports for exactly one cycle
// while rsp_valid is high. The receiver cannot hold a response off.
// Order: the entry read from the RAM is loaded, then two update stages run, then
// the done state writes a sample back and shows the response. Busy is high
// from the accepting edge until the done state ends, so a new request is taken
// only once the last one is through, back in the idle state.
// Reset clears the per-entry valid bits; an entry that is not valid reads as
// the cleared statistics (minimum all ones, all else zero). A clear request
// drops the valid bits of all slots of its thread. Requests are accepted as soon
// as reset is released.
module address_stride_profiler
   import asp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [3:0]          req_thread,
   input  logic [1:0]          req_slot,
   input  logic [ADDR_W-1:0]   req_address,
   output logic                rsp_valid,
   output logic [ADDR_W-1:0]   rsp_min_address,
   output logic [ADDR_W-1:0]   rsp_max_address,
   output logic [COUNT_W-1:0]  rsp_access_count,
   output logic [STRIDE_W-1:0] rsp_first_stride,
   output logic [COUNT_W-1:0]  rsp_first_count,
   output logic [STRIDE_W-1:0] rsp_second_stride,
   output logic [COUNT_W-1:0]  rsp_second_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_STEP1,
      ST_STEP2,
      ST_DONE
   } state_type;

   state_type         state_ff;
   state_type         state_in;
   logic [1:0]        cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ENTRY_W-1:0] idx_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              rsp_valid_ff;

   logic              accept;
   logic [3:0]        thread_mod;
   logic [1:0]        slot_mod;
   logic [ENTRY_W-1:0] req_index;
   logic              is_sample;
   logic              is_clear;
   logic              rd_valid;
   logic [ENTRY_BITS-1:0] rd_bits;
   entry_type         entry;
   ctrl_type          ctrl;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign thread_mod = 4'(req_thread % THREADS);
   assign slot_mod = 2'(req_slot % SLOTS);
   assign req_index = ENTRY_W'(int'(thread_mod) * SLOTS + int'(slot_mod));
   assign is_sample = (cmd_ff == CMD_SAMPLE);
   assign is_clear = (cmd_ff == CMD_CLEAR);

   assign ctrl.load = (state_ff == ST_LOAD);
   assign ctrl.step1 = (state_ff == ST_STEP1);
   assign ctrl.step2 = (state_ff == ST_STEP2);

   always_comb begin
      case (state_ff)
         ST_IDLE:  state_in = accept ? ST_LOAD : ST_IDLE;
         ST_LOAD:  state_in = ST_STEP1;
         ST_STEP1: state_in = ST_STEP2;
         ST_STEP2: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_STEP2);
         if (accept) begin
            cmd_ff <= req_command;
            addr_ff <= req_address;
            idx_ff <= req_index;
            row_ff <= ROW_W'(thread_mod);
         end
      end
   end

   asp_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   ((state_ff == ST_DONE) && is_sample),
      .wr_addr (idx_ff),
      .wr_data (entry),
      .rd_en   (accept),
      .rd_addr (req_index),
      .rd_data (rd_bits)
   );

   asp_valid u_valid (
      .clock     (clock),
      .reset     (reset),
      .set_en    ((state_ff == ST_DONE) && is_sample),
      .set_index (idx_ff),
      .clear_en  ((state_ff == ST_DONE) && is_clear),
      .clear_row (row_ff),
      .rd_index  (idx_ff),
      .rd_valid  (rd_valid)
   );

   asp_update u_update (
      .clock     (clock),
      .ctrl      (ctrl),
      .rd_entry  (entry_type'(rd_bits)),
      .rd_valid  (rd_valid),
      .is_sample (is_sample),
      .is_clear  (is_clear),
      .address   (addr_ff),
      .entry     (entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min_address = entry.low_mark;
   assign rsp_max_address = entry.high_mark;
   assign rsp_access_count = entry.sample_total;
   assign rsp_first_stride = entry.stride_a;
   assign rsp_first_count = entry.tally_a;
   assign rsp_second_stride = entry.stride_b;
   assign rsp_second_count = entry.tally_b;

endmodule

>>> test/asp_tb_pkg.sv
// Request and response types plus the scoreboard for the address stride profiler testbench.
// The scoreboard keeps its own copy of the statistics table and predicts every response.
// Depends on asp_pkg.
package asp_tb_pkg;
   import asp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]        command;
      logic [3:0]        thread;
      logic [1:0]        slot;
      logic [ADDR_W-1:0] address;
   } request_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   min_address;
      logic [ADDR_W-1:0]   max_address;
      logic [COUNT_W-1:0]  access_count;
      logic [STRIDE_W-1:0] first_stride;
      logic [COUNT_W-1:0]  first_count;
      logic [STRIDE_W-1:0] second_stride;
      logic [COUNT_W-1:0]  second_count;
   } slot_report_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   last_addr;
      logic [ADDR_W-1:0]   low_addr;
      logic [ADDR_W-1:0]   high_addr;
      logic [COUNT_W-1:0]  hits;
      logic [STRIDE_W-1:0] first_stride;
      logic [COUNT_W-1:0]  first_tally;
      logic [STRIDE_W-1:0] second_stride;
      logic [COUNT_W-1:0]  second_tally;
   } slot_stats_type;

   class stride_scoreboard;
      slot_stats_type  slot_profile[ENTRIES];
      slot_report_type pending_reports[$];
      int failures;
      int responses;
      int clears;
      int samples;
      int reads;

      function new();
         for (int i = 0; i < ENTRIES; i++) slot_profile[i] = blank_stats();
      endfunction

      function slot_stats_type blank_stats();
         slot_stats_type s;
         s = '0;
         s.low_addr = '1;
         return s;
      endfunction

      function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] value);
         return (value == '1) ? value : value + COUNT_W'(1);
      endfunction

      function int pending();
         return pending_reports.size();
      endfunction

      function string describe(slot_report_type r);
         return $sformatf("min=%h max=%h count=%h stride1=%h count1=%h stride2=%h count2=%h",
            r.min_address, r.max_address, r.access_count, r.first_stride, r.first_count,
            r.second_stride, r.second_count);
      endfunction

      function void note_request(request_type req);
         int row;
         int entry;
         logic [ADDR_W-1:0] gap;
         logic [STRIDE_W-1:0] stride;
         slot_stats_type s;
         slot_report_type report;
         row = int'(req.thread) % THREADS;
         entry = row * SLOTS + int'(req.slot) % SLOTS;
         case (req.command)
            CMD_CLEAR: begin
               for (int i = 0; i < SLOTS; i++) slot_profile[row * SLOTS + i] = blank_stats();
               clears++;
            end
            CMD_SAMPLE: begin
               s = slot_profile[entry];
               if (req.address < s.low_addr) s.low_addr = req.address;
               if (req.address > s.high_addr) s.high_addr = req.address;
               s.hits = bump(s.hits);
               gap = (req.address >= s.last_addr) ? req.address - s.last_addr
                                                  : s.last_addr - req.address;
               stride = STRIDE_W'((gap > STRIDE_LIMIT) ? STRIDE_LIMIT : gap);
               s.last_addr = req.address;
               if (stride == s.first_stride) s.first_tally = bump(s.first_tally);
               else if (stride == s.second_stride) s.second_tally = bump(s.second_tally);
               else if (s.first_tally == '0) s.first_stride = stride;
               else if (s.second_tally == '0) s.second_stride = stride;
               else if (s.second_tally >= s.first_tally)
                  s.second_tally = s.second_tally - COUNT_W'(1);
               else s.first_tally = s.first_tally - COUNT_W'(1);
               slot_profile[entry] = s;
               samples++;
            end
            default: begin
               reads++;
            end
         endcase
         s = slot_profile[entry];
         report = '{s.low_addr, s.high_addr, s.hits, s.first_stride, s.first_tally,
                    s.second_stride, s.second_tally};
         pending_reports.push_back(report);
      endfunction

      function void check_report(slot_report_type got);
         slot_report_type want;
         if (pending_reports.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected response: %s", describe(got));
            return;
         end
         want = pending_reports.pop_front();
         responses++;
         if (want.min_address !== got.min_address || want.max_address !== got.max_address ||
             want.access_count !== got.access_count || want.first_stride !== got.first_stride ||
             want.first_count !== got.first_count || want.second_stride !== got.second_stride ||
             want.second_count !== got.second_count) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch on response %0d", responses);
               $display("  expected %s", describe(want));
               $display("  actual   %s", describe(got));
            end
         end
      endfunction
   endclass

endpackage

>>> test/testbench.sv
// Top of the address stride profiler testbench: directed and random requests, with
// random idle bursts, and every response checked through stride_scoreboard.
// Depends on asp_pkg, asp_tb_pkg and the address_stride_profiler RTL.
module testbench;
   import asp_pkg::*;
   import asp_tb_pkg::*;

   localparam int RANDOM_REQUESTS = 1300;
   localparam int CALM_TAIL = 150;
   localparam int WATCHDOG_LIMIT = 300;
   localparam int DRAIN_CYCLES = 12;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_command;
   logic [3:0]          req_thread;
   logic [1:0]          req_slot;
   logic [ADDR_W-1:0]   req_address;
   logic                rsp_valid;
   logic [ADDR_W-1:0]   rsp_min_address;
   logic [ADDR_W-1:0]   rsp_max_address;
   logic [COUNT_W-1:0]  rsp_access_count;
   logic [STRIDE_W-1:0] rsp_first_stride;
   logic [COUNT_W-1:0]  rsp_first_count;
   logic [STRIDE_W-1:0] rsp_second_stride;
   logic [COUNT_W-1:0]  rsp_second_count;

   stride_scoreboard board;
   slot_report_type  seen_report;
   int requests_sent;
   int tail_start;
   int random_stop;
   int pause_pct;
   int idle_cycles;

   address_stride_profiler dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [ADDR_W-1:0] any_address();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ADDR_W-1:0] pick_stride();
      case ($urandom_range(0, 4))
         0: return ADDR_W'(8 * $urandom_range(1, 16));
         1: return ADDR_W'($urandom_range(0, 4096));
         2: return ADDR_W'($urandom() & 32'h7FFF_FFFF);
         3: return STRIDE_LIMIT + ADDR_W'($urandom_range(0, 2)) - ADDR_W'(1);
         default: return any_address();
      endcase
   endfunction

   task automatic send(input logic [1:0] command, input logic [3:0] thread,
                       input logic [1:0] slot, input logic [ADDR_W-1:0] address);
      request_type req;
      req = '{command, thread, slot, address};
      start <= 1'b1;
      req_command <= command;
      req_thread <= thread;
      req_slot <= slot;
      req_address <= address;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_request(req);
      requests_sent++;
      if (requests_sent % 64 == 0) begin
         case ($urandom_range(0, 2))
            0: pause_pct = 0;
            1: pause_pct = 25;
            default: pause_pct = 70;
         endcase
      end
      if (requests_sent < tail_start && $urandom_range(0, 99) < pause_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic run_stream();
      logic [3:0] thr;
      logic [1:0] slt;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] main_step;
      logic [ADDR_W-1:0] alt_step;
      logic [ADDR_W-1:0] step;
      bit down;
      int len;
      int roll;
      thr = 4'($urandom_range(0, 15));
      slt = 2'($urandom_range(0, 3));
      addr = any_address();
      down = ($urandom_range(0, 1) == 1);
      main_step = pick_stride();
      alt_step = pick_stride();
      len = $urandom_range(4, 24);
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 65) step = main_step;
         else if (roll < 85) step = alt_step;
         else if (roll < 90) step = '0;
         else step = any_address();
         addr = down ? addr - step : addr + step;
         send(CMD_SAMPLE, thr, slt, addr);
         roll = $urandom_range(0, 99);
         if (roll < 10) send(CMD_READ, thr, slt, any_address());
         else if (roll < 13) send(CMD_UNUSED, thr, slt, any_address());
         else if (roll < 15) send(CMD_CLEAR, thr, 2'($urandom_range(0, 3)), any_address());
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         seen_report = '{rsp_min_address, rsp_max_address, rsp_access_count, rsp_first_stride,
                         rsp_first_count, rsp_second_stride, rsp_second_count};
         board.check_report(seen_report);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int roll;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_READ;
      req_thread = '0;
      req_slot = '0;
      req_address = '0;
      requests_sent = 0;
      pause_pct = 25;
      tail_start = 32'h7FFF_FFFF;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Boundary addresses, saturated strides and the unused command code.
      send(CMD_READ, 4'd0, 2'd0, '0);
      send(CMD_UNUSED, 4'd15, 2'd3, '1);
      send(CMD_SAMPLE, 4'd15, 2'd3, '1);
      send(CMD_SAMPLE, 4'd15, 2'd3, '0);
      send(CMD_SAMPLE, 4'd15, 2'd3, '0);
      send(CMD_SAMPLE, 4'd15, 2'd3, 48'h0000_7FFF_FFFF);
      send(CMD_SAMPLE, 4'd15, 2'd3, 48'h0000_FFFF_FFFF);
      send(CMD_UNUSED, 4'd15, 2'd3, '0);
      // Walk the two stride candidates through hits, misses and replacement.
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd8);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd16);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd24);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd124);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd224);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd1224);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd2224);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd3224);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'd3216);
      send(CMD_READ, 4'd1, 2'd1, '1);
      // A clear hits every slot of the thread, not only the addressed one.
      send(CMD_CLEAR, 4'd1, 2'd2, '1);
      send(CMD_READ, 4'd1, 2'd1, '0);
      send(CMD_CLEAR, 4'd0, 2'd0, '0);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'h5555_5555_5555);
      send(CMD_SAMPLE, 4'd1, 2'd1, 48'hAAAA_AAAA_AAAA);

      tail_start = requests_sent + RANDOM_REQUESTS - CALM_TAIL;
      random_stop = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < random_stop) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) run_stream();
         else if (roll < 76)
            send(CMD_CLEAR, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), any_address());
         else if (roll < 88)
            send(2'($urandom_range(CMD_READ, CMD_UNUSED)), 4'($urandom_range(0, 15)),
                 2'($urandom_range(0, 3)), any_address());
         else
            send(CMD_SAMPLE, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), any_address());
      end

      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests: %0d clears, %0d samples, %0d reads; checked %0d responses.",
               requests_sent, board.clears, board.samples, board.reads, board.responses);
      $display("Failures found: %0d.", board.failures);
      if (board.failures == 0 && board.pending() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/core/asp_pkg.sv
rtl/core/asp_ram.sv
rtl/core/asp_valid.sv
rtl/core/asp_update.sv
rtl/core/address_stride_profiler.sv
test/asp_tb_pkg.sv
test/testbench.sv
